// ===== rtl/nearest_k_sorted_list_unit_assert.svh =====
// Assertion macros shared by the block's modules.
`ifndef NEAREST_K_SORTED_LIST_UNIT_ASSERT_SVH
`define NEAREST_K_SORTED_LIST_UNIT_ASSERT_SVH
// An antecedent implies a consequent in the same cycle.
`define NKS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// An antecedent implies a consequent in the next cycle.
`define NKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/nks_pkg.sv =====
`default_nettype none
package nks_pkg;
    localparam int HANDLE_W = 32;
    localparam int DIST_W   = 50;
    localparam int SLOT_W   = 4;

    typedef enum logic [0:0] {
        ACT_UPDATE = 1'b0,
        ACT_READ   = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIST,
        BK_SCAN,
        BK_SHIFT,
        BK_DONE
    } back_state_t;
endpackage
`default_nettype wire

// ===== rtl/nearest_k_sorted_list_unit.sv =====
`default_nettype none
`include "nearest_k_sorted_list_unit_assert.svh"
// Keeps per observer a list of the LIST_DEPTH nearest handles sorted by
// squared distance. Raise start with a command word while busy is low; each
// word produces exactly one result, shown for one cycle with done high, and
// the receiver cannot hold it off. busy stays high from acceptance until the
// result has been shown, so one word is in flight at a time. A read passes
// the front stages, the queue and the back part's distance, shift and done
// states; an update also scans the list one entry at a time and moves each
// shifted entry with a read phase and then a write phase.
module nearest_k_sorted_list_unit #(
    parameter int LIST_DEPTH = 10,
    parameter int OBSERVERS  = 4,
    parameter int COORD_BITS = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    output logic                               done,
    input  wire logic                          action,
    input  wire logic [1:0]                    observer_index,
    input  wire logic [31:0]                   object_handle,
    input  wire logic signed [COORD_BITS-1:0]  observer_x,
    input  wire logic signed [COORD_BITS-1:0]  observer_y,
    input  wire logic signed [COORD_BITS-1:0]  observer_z,
    input  wire logic signed [COORD_BITS-1:0]  object_x,
    input  wire logic signed [COORD_BITS-1:0]  object_y,
    input  wire logic signed [COORD_BITS-1:0]  object_z,
    input  wire logic [3:0]                    read_slot,
    output logic                               entry_valid,
    output logic [31:0]                        entry_handle,
    output logic [49:0]                        entry_distance,
    output logic [3:0]                         insert_position,
    output logic [3:0]                         list_count
);
    localparam int OBS_W = 2;
    localparam int QW = 1 + OBS_W + 32 + 4 + 50;

    logic take, f_valid, q_ne, q_full, pop, back_busy;
    nks_pkg::action_t f_act;
    logic [OBS_W-1:0] f_obs;
    logic [31:0] f_hnd;
    logic [3:0] f_slot;
    logic [49:0] f_dist;
    logic [QW-1:0] q_head;
    logic inflight_reg;

    assign take = start && !busy;

    // One word in flight from acceptance to its result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= 1'b0;
        else if (take)
            inflight_reg <= 1'b1;
        else if (done)
            inflight_reg <= 1'b0;
    end
    assign busy = inflight_reg;

    nks_front #(.OBS_W(OBS_W), .COORD_BITS(COORD_BITS)) u_front (
        .clk, .rst_n, .take,
        .action(nks_pkg::action_t'(action)), .observer_index, .object_handle,
        .observer_x, .observer_y, .observer_z, .object_x, .object_y, .object_z,
        .read_slot,
        .word_valid(f_valid), .word_action(f_act), .word_obs(f_obs),
        .word_handle(f_hnd), .word_slot(f_slot), .word_dist(f_dist)
    );

    nks_queue #(.WIDTH(QW)) u_queue (
        .clk, .rst_n, .push(f_valid),
        .push_data({f_act, f_obs, f_hnd, f_slot, f_dist}),
        .pop, .not_empty(q_ne), .full(q_full), .head(q_head)
    );

    nks_back #(.LIST_DEPTH(LIST_DEPTH), .OBSERVERS(OBSERVERS), .OBS_W(OBS_W)) u_back (
        .clk, .rst_n, .word_ready(q_ne),
        .word_action(nks_pkg::action_t'(q_head[QW-1])),
        .word_obs(q_head[QW-2 -: OBS_W]),
        .word_handle(q_head[85:54]),
        .word_slot(q_head[53:50]),
        .word_dist(q_head[49:0]),
        .word_pop(pop), .busy_back(back_busy), .done,
        .entry_valid, .entry_handle, .entry_distance, .insert_position, .list_count
    );

    `NKS_ASSERT_IMP(a_done_busy, clk, rst_n, done, busy,
        "result without a word in flight")
    `NKS_ASSERT_IMP(a_queue_room, clk, rst_n, f_valid, !q_full,
        "queue overflow")
    `NKS_ASSERT_IMP(a_back_busy_flight, clk, rst_n, back_busy, inflight_reg,
        "back part active with nothing in flight")
endmodule
`default_nettype wire

// ===== rtl/nks_front.sv =====
`default_nettype none
// Front part: takes a command word, squares the axis differences and sums
// them, then hands a classified word to the queue.
module nks_front #(
    parameter int OBS_W      = 2,
    parameter int COORD_BITS = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          take,
    input  wire nks_pkg::action_t              action,
    input  wire logic [OBS_W-1:0]              observer_index,
    input  wire logic [nks_pkg::HANDLE_W-1:0]  object_handle,
    input  wire logic signed [COORD_BITS-1:0]  observer_x,
    input  wire logic signed [COORD_BITS-1:0]  observer_y,
    input  wire logic signed [COORD_BITS-1:0]  observer_z,
    input  wire logic signed [COORD_BITS-1:0]  object_x,
    input  wire logic signed [COORD_BITS-1:0]  object_y,
    input  wire logic signed [COORD_BITS-1:0]  object_z,
    input  wire logic [nks_pkg::SLOT_W-1:0]    read_slot,
    output logic                               word_valid,
    output nks_pkg::action_t                   word_action,
    output logic [OBS_W-1:0]                   word_obs,
    output logic [nks_pkg::HANDLE_W-1:0]       word_handle,
    output logic [nks_pkg::SLOT_W-1:0]         word_slot,
    output logic [nks_pkg::DIST_W-1:0]         word_dist
);
    localparam int DW = COORD_BITS + 1;
    localparam int SW = 2 * DW;

    logic [1:0] stage_reg, stage_next;
    nks_pkg::action_t act_reg;
    logic [OBS_W-1:0] obs_reg;
    logic [nks_pkg::HANDLE_W-1:0] hnd_reg;
    logic [nks_pkg::SLOT_W-1:0] slot_reg;
    logic [DW-1:0] mx_reg, my_reg, mz_reg;
    logic [SW-1:0] sx_reg, sy_reg, sz_reg;
    logic [SW+1:0] sum;
    logic signed [DW-1:0] dx, dy, dz;

    // Axis differences and their magnitudes.
    always_comb
    begin
        dx = DW'(object_x) - DW'(observer_x);
        dy = DW'(object_y) - DW'(observer_y);
        dz = DW'(object_z) - DW'(observer_z);
        dx = $signed(DW'({object_x[COORD_BITS-1], object_x}))
           - $signed(DW'({observer_x[COORD_BITS-1], observer_x}));
        dy = $signed(DW'({object_y[COORD_BITS-1], object_y}))
           - $signed(DW'({observer_y[COORD_BITS-1], observer_y}));
        dz = $signed(DW'({object_z[COORD_BITS-1], object_z}))
           - $signed(DW'({observer_z[COORD_BITS-1], observer_z}));
        stage_next = (stage_reg == 2'd0) ? (take ? 2'd1 : 2'd0)
                   : (stage_reg == 2'd2) ? 2'd0 : stage_reg + 2'd1;
    end

    // Stage sequencer: magnitudes, squares, then sum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 2'd0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    // Data registers of the magnitude and square stages.
    always_ff @(posedge clk)
    begin
        if (take && stage_reg == 2'd0)
        begin
            act_reg  <= action;
            obs_reg  <= observer_index;
            hnd_reg  <= object_handle;
            slot_reg <= read_slot;
            mx_reg   <= dx[DW-1] ? DW'(-dx) : DW'(dx);
            my_reg   <= dy[DW-1] ? DW'(-dy) : DW'(dy);
            mz_reg   <= dz[DW-1] ? DW'(-dz) : DW'(dz);
        end
        if (stage_reg == 2'd1)
        begin
            sx_reg <= mx_reg * mx_reg;
            sy_reg <= my_reg * my_reg;
            sz_reg <= mz_reg * mz_reg;
        end
    end

    // Sum with saturation to the distance width.
    always_comb
    begin
        sum = (SW+2)'(sx_reg) + (SW+2)'(sy_reg) + (SW+2)'(sz_reg);
        if ((SW + 2) > nks_pkg::DIST_W && (sum >> nks_pkg::DIST_W) != '0)
            word_dist = '1;
        else
            word_dist = nks_pkg::DIST_W'(sum);
        word_valid  = (stage_reg == 2'd2);
        word_action = act_reg;
        word_obs    = obs_reg;
        word_handle = hnd_reg;
        word_slot   = slot_reg;
    end
endmodule
`default_nettype wire

// ===== rtl/nks_queue.sv =====
`default_nettype none
// Two-entry queue between the front and back parts.
module nks_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic                  full,
    output logic [WIDTH-1:0]      head
);
    logic [WIDTH-1:0] mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end

    assign not_empty = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'd2);
    assign head      = mem_reg[rp_reg];
endmodule
`default_nettype wire

// ===== rtl/nks_back.sv =====
`default_nettype none
`include "nearest_k_sorted_list_unit_assert.svh"
// Back part: walks one observer's list; the scan reads one slot a cycle. It
// finds the old copy of the handle and the lower bound; the shift pass moves entries.
module nks_back #(
    parameter int LIST_DEPTH = 10,
    parameter int OBSERVERS  = 4,
    parameter int OBS_W      = 2
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          word_ready,
    input  wire nks_pkg::action_t              word_action,
    input  wire logic [OBS_W-1:0]              word_obs,
    input  wire logic [nks_pkg::HANDLE_W-1:0]  word_handle,
    input  wire logic [nks_pkg::SLOT_W-1:0]    word_slot,
    input  wire logic [nks_pkg::DIST_W-1:0]    word_dist,
    output logic                               word_pop,
    output logic                               busy_back,
    output logic                               done,
    output logic                               entry_valid,
    output logic [nks_pkg::HANDLE_W-1:0]       entry_handle,
    output logic [nks_pkg::DIST_W-1:0]         entry_distance,
    output logic [nks_pkg::SLOT_W-1:0]         insert_position,
    output logic [nks_pkg::SLOT_W-1:0]         list_count
);
    localparam int DEPTH = OBSERVERS * LIST_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = $clog2(LIST_DEPTH + 1) + 1;
    localparam int CW    = nks_pkg::SLOT_W;

    typedef struct packed {
        logic [nks_pkg::HANDLE_W-1:0] h;
        logic [nks_pkg::DIST_W-1:0]   d;
    } entry_t;

    entry_t mem [DEPTH];
    entry_t rd_reg;
    logic [CW-1:0] cnt_reg [OBSERVERS];

    nks_pkg::back_state_t st_reg, st_next;
    nks_pkg::action_t act_reg;
    logic [OBS_W-1:0] obs_reg;
    logic [nks_pkg::HANDLE_W-1:0] hnd_reg;
    logic [nks_pkg::DIST_W-1:0] dist_reg;
    logic [CW-1:0] slot_reg;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] n_reg;
    logic found_reg;
    logic [IW-1:0] rem_reg;
    logic lb_found_reg;
    logic [IW-1:0] lb_reg;
    logic [IW-1:0] cnt2;
    logic [IW-1:0] pos;
    logic [IW-1:0] newcnt;
    logic [IW-1:0] shift_hi;
    logic valid_obs;
    logic [AW-1:0] base;
    logic rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    entry_t wr_data;
    logic [1:0] sh_ph_reg;
    logic [IW-1:0] wi_reg;

    assign valid_obs = (32'(obs_reg) < OBSERVERS);
    assign base = AW'(32'(obs_reg) * LIST_DEPTH);

    // List length after removing the old copy, lower bound, final count.
    always_comb
    begin
        cnt2 = found_reg ? n_reg - IW'(1) : n_reg;
        pos = lb_found_reg ? lb_reg : cnt2;
        if (pos >= IW'(LIST_DEPTH))
            newcnt = cnt2;
        else
            newcnt = (cnt2 == IW'(LIST_DEPTH)) ? cnt2 : cnt2 + IW'(1);
        shift_hi = (cnt2 == IW'(LIST_DEPTH)) ? cnt2 - IW'(1) : cnt2;
    end

    // Next state.
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            nks_pkg::BK_IDLE:
                if (word_ready)
                    st_next = nks_pkg::BK_DIST;
            nks_pkg::BK_DIST:
                if (!valid_obs || act_reg == nks_pkg::ACT_READ || n_reg == '0)
                    st_next = nks_pkg::BK_SHIFT;
                else
                    st_next = nks_pkg::BK_SCAN;
            nks_pkg::BK_SCAN:
                if (idx_next == n_reg)
                    st_next = nks_pkg::BK_SHIFT;
            nks_pkg::BK_SHIFT:
                if (act_reg == nks_pkg::ACT_READ || !valid_obs
                    || (sh_ph_reg == 2'd3))
                    st_next = nks_pkg::BK_DONE;
            nks_pkg::BK_DONE:
                st_next = nks_pkg::BK_IDLE;
            default:
                st_next = nks_pkg::BK_IDLE;
        endcase
    end

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= nks_pkg::BK_IDLE;
            for (int i = 0; i < OBSERVERS; i++)
                cnt_reg[i] <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == nks_pkg::BK_DONE && act_reg == nks_pkg::ACT_UPDATE
                && valid_obs)
                cnt_reg[obs_reg[OBS_W-1:0]] <= CW'(newcnt);
        end
    end

    // Memory read and write addresses in the distance state, the scan and the shift pass.
    always_comb
    begin
        idx_next = idx_reg + IW'(1);
        rd_en = 1'b0;
        rd_addr = base;
        wr_en = 1'b0;
        wr_addr = base;
        wr_data = '{h: hnd_reg, d: dist_reg};
        case (st_reg)
            nks_pkg::BK_DIST:
            begin
                rd_en = 1'b1;
                rd_addr = (act_reg == nks_pkg::ACT_READ)
                        ? base + AW'(slot_reg) : base;
            end
            nks_pkg::BK_SCAN:
            begin
                rd_en = 1'b1;
                rd_addr = base + AW'(idx_next);
            end
            nks_pkg::BK_SHIFT:
            begin
                // A read keeps the entry fetched in the previous state.
                rd_en = (act_reg == nks_pkg::ACT_UPDATE);
                rd_addr = base + AW'(wi_reg);
                if (sh_ph_reg == 2'd2)
                begin
                    wr_en = 1'b1;
                    wr_addr = (rem_reg < n_reg) ? base + AW'(rem_reg)
                            : base + AW'(wi_reg + IW'(1));
                    wr_data = rd_reg;
                end
                if (sh_ph_reg == 2'd3 && pos < IW'(LIST_DEPTH))
                begin
                    wr_en = 1'b1;
                    wr_addr = base + AW'(pos);
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Entry memory.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

    // Item registers, scan bookkeeping and the shift walk. The shift pass
    // first closes the gap of a removed copy walking upward, then opens a
    // gap at the lower bound walking downward, reading each entry, then writing it.
    always_ff @(posedge clk)
    begin
        case (st_reg)
            nks_pkg::BK_IDLE:
            begin
                act_reg  <= word_action;
                obs_reg  <= word_obs;
                hnd_reg  <= word_handle;
                dist_reg <= word_dist;
                slot_reg <= word_slot;
                idx_reg  <= '0;
                found_reg <= 1'b0;
                lb_found_reg <= 1'b0;
                rem_reg <= '0;
                lb_reg <= '0;
                if (32'(word_obs) < OBSERVERS)
                    n_reg <= (cnt_reg[word_obs] > CW'(LIST_DEPTH))
                           ? IW'(LIST_DEPTH) : IW'(cnt_reg[word_obs]);
                else
                    n_reg <= '0;
            end
            nks_pkg::BK_DIST:
            begin
                sh_ph_reg <= 2'd0;
            end
            nks_pkg::BK_SCAN:
            begin
                idx_reg <= idx_next;
                if (!found_reg && rd_reg.h == hnd_reg)
                begin
                    found_reg <= 1'b1;
                    rem_reg <= idx_reg;
                end
                else if (!lb_found_reg && rd_reg.d >= dist_reg)
                begin
                    lb_found_reg <= 1'b1;
                    lb_reg <= found_reg ? idx_reg - IW'(1) : idx_reg;
                end
                if (idx_next == n_reg)
                begin
                    sh_ph_reg <= 2'd0;
                    wi_reg <= '0;
                end
            end
            nks_pkg::BK_SHIFT:
            begin
                case (sh_ph_reg)
                    2'd0:
                    begin
                        if (found_reg && rem_reg + IW'(1) < n_reg)
                        begin
                            wi_reg <= rem_reg + IW'(1);
                            sh_ph_reg <= 2'd1;
                        end
                        else
                        begin
                            wi_reg <= (shift_hi > pos) ? shift_hi - IW'(1) : shift_hi;
                            found_reg <= found_reg;
                            rem_reg <= n_reg;
                            sh_ph_reg <= (shift_hi > pos) ? 2'd1 : 2'd3;
                        end
                    end
                    2'd1:
                        sh_ph_reg <= 2'd2;
                    2'd2:
                    begin
                        // Upward pass writes down one; downward writes up one.
                        if (rem_reg < n_reg)
                        begin
                            if (wi_reg + IW'(1) < n_reg)
                            begin
                                rem_reg <= wi_reg;
                                wi_reg <= wi_reg + IW'(1);
                                sh_ph_reg <= 2'd1;
                            end
                            else
                            begin
                                rem_reg <= n_reg;
                                wi_reg <= (shift_hi > pos) ? shift_hi - IW'(1) : shift_hi;
                                sh_ph_reg <= (shift_hi > pos) ? 2'd1 : 2'd3;
                            end
                        end
                        else if (wi_reg > pos)
                        begin
                            wi_reg <= wi_reg - IW'(1);
                            sh_ph_reg <= 2'd1;
                        end
                        else
                            sh_ph_reg <= 2'd3;
                    end
                    default:
                        sh_ph_reg <= 2'd3;
                endcase
            end
            default:
            begin
                sh_ph_reg <= 2'd0;
            end
        endcase
    end

    // Result word.
    always_comb
    begin
        word_pop = (st_reg == nks_pkg::BK_IDLE) && word_ready;
        busy_back = (st_reg != nks_pkg::BK_IDLE);
        done = (st_reg == nks_pkg::BK_DONE);
        entry_valid = 1'b0;
        entry_handle = '0;
        entry_distance = '0;
        insert_position = '0;
        list_count = '0;
        if (valid_obs)
        begin
            if (act_reg == nks_pkg::ACT_READ)
            begin
                list_count = CW'(n_reg);
                if (IW'(slot_reg) < n_reg)
                begin
                    entry_valid = 1'b1;
                    entry_handle = rd_reg.h;
                    entry_distance = rd_reg.d;
                end
            end
            else
            begin
                entry_valid = 1'b1;
                entry_handle = hnd_reg;
                entry_distance = dist_reg;
                insert_position = (pos >= IW'(LIST_DEPTH)) ? CW'(LIST_DEPTH) : CW'(pos);
                list_count = CW'(newcnt);
            end
        end
    end

    `NKS_ASSERT_IMP(a_done_once, clk, rst_n, done, (st_next == nks_pkg::BK_IDLE),
        "result strobe lasts more than one cycle")
    `NKS_ASSERT_IMP(a_wr_range, clk, rst_n, wr_en, (32'(wr_addr) < DEPTH),
        "list write outside the memory")
    `NKS_ASSERT_NEXT(a_pop_starts, clk, rst_n, word_pop, (st_reg == nks_pkg::BK_DIST),
        "popped word did not start the back part")
endmodule
`default_nettype wire
